// File: rtl/ssh_pkg.sv
// Package: types, constants and compare helper for the sorter block (shell_sort_halving_gaps).
`default_nettype none
package ssh_pkg;

  localparam int MaxElements = 16;
  localparam int CntW        = $clog2(MaxElements + 1);
  localparam int PhaseW      = $clog2(MaxElements);

  typedef struct packed {
    logic signed [31:0] value;
    logic               is_last;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] sorted_value;
    logic               end_of_set;
    logic               overflowed;
  } out_res_t;

  // One slot of the sorting chain; an empty slot ranks above any value.
  typedef struct packed {
    logic               vld;
    logic signed [31:0] val;
  } slot_t;

  typedef struct packed {
    logic load;
    logic sort;
    logic phase;
    logic unload;
    logic last;
    logic ovf;
  } ctl_t;

  function automatic logic slot_gt(slot_t a, slot_t b);
    logic r;
    if (!a.vld) begin
      r = b.vld;
    end else if (!b.vld) begin
      r = 1'b0;
    end else begin
      r = (a.val > b.val);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/ssh_cell.sv
// One compare-exchange cell of the odd-even transposition chain.
`default_nettype none
module ssh_cell (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire ssh_pkg::ctl_t ctl_i,
  input  wire logic          odd_i,
  input  wire ssh_pkg::slot_t left_i,
  input  wire ssh_pkg::slot_t right_i,
  output ssh_pkg::slot_t     q_o
);
  import ssh_pkg::*;

  slot_t slot_q, slot_d;
  logic  pair_left;

  assign pair_left = (odd_i == ctl_i.phase);

  always_comb begin
    slot_d = slot_q;
    if (ctl_i.load) begin
      slot_d = left_i;
    end else if (ctl_i.unload) begin
      slot_d = right_i;
    end else if (ctl_i.sort) begin
      if (pair_left) begin
        if (slot_gt(slot_q, right_i)) slot_d = right_i;
      end else begin
        if (slot_gt(left_i, slot_q)) slot_d = left_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else begin
      slot_q <= slot_d;
    end
  end

  assign q_o = slot_q;

endmodule
`default_nettype wire

// File: rtl/ssh_ctrl.sv
// Sequencer: load, sort phases and unload of the cell chain.
`default_nettype none
module ssh_ctrl (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   start,
  input  wire logic   is_last_i,
  output ssh_pkg::ctl_t ctl_o
);
  import ssh_pkg::*;

  localparam logic [1:0] StLoad   = 2'd0;
  localparam logic [1:0] StSort   = 2'd1;
  localparam logic [1:0] StUnload = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [PhaseW-1:0] phase_q, phase_d;
  logic              ovf_q, ovf_d;
  logic              room, take;

  assign room = (count_q < CntW'(MaxElements));
  assign take = (state_q == StLoad) && start;

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    phase_d = phase_q;
    ovf_d   = ovf_q;
    unique case (state_q)
      StLoad: begin
        if (take) begin
          if (room) begin
            count_d = count_q + CntW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (is_last_i) begin
            state_d = StSort;
            phase_d = '0;
          end
        end
      end
      StSort: begin
        phase_d = phase_q + PhaseW'(1);
        if (phase_q == PhaseW'(MaxElements - 1)) begin
          state_d = StUnload;
        end
      end
      StUnload: begin
        count_d = count_q - CntW'(1);
        if (count_q == CntW'(1)) begin
          state_d = StLoad;
          ovf_d   = 1'b0;
        end
      end
      default: begin
        state_d = StLoad;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
      count_q <= '0;
      phase_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      phase_q <= phase_d;
      ovf_q   <= ovf_d;
    end
  end

  assign ctl_o.load   = take && room;
  assign ctl_o.sort   = (state_q == StSort);
  assign ctl_o.phase  = phase_q[0];
  assign ctl_o.unload = (state_q == StUnload);
  assign ctl_o.last   = (count_q == CntW'(1));
  assign ctl_o.ovf    = ovf_q;

endmodule
`default_nettype wire

// File: rtl/shell_sort_halving_gaps.sv
// Top level: sorter built from a chain of compare-exchange cells.
// Sequence: after the request flagged last, the sort phases run, then one result per cycle.
// Throughput: one request per cycle while loading; no new set is taken until the last is unloaded.
// The sort runs 16 odd-even phases over the cell chain.
// Reset: asynchronous, active low; clears the sequencer and empties every cell.
// Results appear for one cycle each on res_valid_o; the receiver cannot stall.
`default_nettype none
module shell_sort_halving_gaps (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire ssh_pkg::in_req_t req_i,
  output logic                  res_valid_o,
  output ssh_pkg::out_res_t     res_o
);
  import ssh_pkg::*;

  ctl_t  ctl;
  slot_t cell_q [MaxElements];
  slot_t new_slot;
  slot_t empty_slot;

  assign new_slot.vld   = 1'b1;
  assign new_slot.val   = req_i.value;
  assign empty_slot.vld = 1'b0;
  assign empty_slot.val = '0;

  ssh_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .is_last_i (req_i.is_last),
    .ctl_o     (ctl)
  );

  for (genvar i = 0; i < MaxElements; i++) begin : g_cell
    slot_t left_s, right_s;
    if (i == 0) begin : g_first
      assign left_s = ctl.load ? new_slot : cell_q[i];
    end else begin : g_mid_l
      assign left_s = cell_q[i-1];
    end
    if (i == MaxElements - 1) begin : g_last
      assign right_s = ctl.unload ? empty_slot : cell_q[i];
    end else begin : g_mid_r
      assign right_s = cell_q[i+1];
    end
    ssh_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .odd_i   ((i % 2) == 1),
      .left_i  (left_s),
      .right_i (right_s),
      .q_o     (cell_q[i])
    );
  end

  assign busy               = ctl.sort || ctl.unload;
  assign res_valid_o        = ctl.unload;
  assign res_o.sorted_value = cell_q[0].val;
  assign res_o.end_of_set   = ctl.last;
  assign res_o.overflowed   = ctl.ovf;

endmodule
`default_nettype wire

// File: rtl/ssh_checker.sv
// Port checker for the sorter, bound to the top level.
`default_nettype none
module ssh_checker (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             start,
  input wire logic             busy,
  input wire ssh_pkg::in_req_t req_i,
  input wire logic             res_valid_o,
  input wire ssh_pkg::out_res_t res_o
);

  a_res_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> busy) else $error("result while not busy");

  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && req_i.is_last |=> busy) else $error("last request did not start sort");

  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.end_of_set |=> res_valid_o) else $error("gap in result burst");

  a_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.end_of_set |=> !res_valid_o) else $error("result after end of set");

  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && $past(res_valid_o) |->
      ($past(res_o.sorted_value) <= res_o.sorted_value)) else $error("results out of order");

endmodule

bind shell_sort_halving_gaps ssh_checker u_ssh_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .req_i       (req_i),
  .res_valid_o (res_valid_o),
  .res_o       (res_o)
);
`default_nettype wire

// File: verif/shell_sort_halving_gaps_tb.sv
// Testbench for shell_sort_halving_gaps: random sets in, sorted results checked in order.
`timescale 1ns / 100ps
module shell_sort_halving_gaps_tb;
  import ssh_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned TailCycles = 60;
  localparam int unsigned RandItems  = 400;
  localparam logic signed [31:0] ValMin = 32'sh8000_0000;
  localparam logic signed [31:0] ValMax = 32'sh7fff_ffff;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start = 1'b0;
  in_req_t  req = '0;
  logic     busy;
  logic     res_valid_o;
  out_res_t res_o;

  shell_sort_halving_gaps i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  in_req_t            req_queue[$];
  out_res_t           sorted_expect[$];
  logic signed [31:0] elem_buf[MaxElements];
  int unsigned        elem_cnt;
  logic               dropped;
  int unsigned        n_sent;
  int unsigned        hold_at;
  int unsigned        n_errors;
  int unsigned        cycles;

  // halving-gap insertion passes over the stored set
  function automatic void sort_elements(int unsigned n);
    int unsigned        gap;
    int unsigned        pos;
    logic signed [31:0] held;
    for (gap = n >> 1; gap > 0; gap = gap >> 1) begin
      for (int unsigned i = gap; i < n; i++) begin
        held = elem_buf[i];
        pos = i;
        while (pos >= gap && elem_buf[pos - gap] > held) begin
          elem_buf[pos] = elem_buf[pos - gap];
          pos = pos - gap;
        end
        elem_buf[pos] = held;
      end
    end
  endfunction

  function automatic void absorb_element(in_req_t r);
    out_res_t o;
    if (elem_cnt < MaxElements) begin
      elem_buf[elem_cnt] = r.value;
      elem_cnt++;
    end else begin
      dropped = 1'b1;
    end
    if (r.is_last) begin
      sort_elements(elem_cnt);
      for (int unsigned k = 0; k < elem_cnt; k++) begin
        o.sorted_value = elem_buf[k];
        o.end_of_set   = (k + 1 == elem_cnt);
        o.overflowed   = dropped;
        sorted_expect = {sorted_expect, o};
      end
      elem_cnt = 0;
      dropped  = 1'b0;
    end
  endfunction

  function automatic logic signed [31:0] pick_value(int unsigned flavor);
    logic signed [31:0] v;
    case (flavor)
      0: v = $signed(32'($urandom_range(0, 15))) - 32'sd8;
      1: begin
        case ($urandom_range(0, 4))
          0: v = ValMin;
          1: v = ValMax;
          2: v = 32'sd0;
          3: v = -32'sd1;
          default: v = $signed($urandom);
        endcase
      end
      2: v = $signed(32'($urandom_range(0, 3)) << 30);
      default: v = $signed($urandom);
    endcase
    return v;
  endfunction

  task automatic queue_set(int unsigned n, int unsigned flavor);
    in_req_t r;
    for (int unsigned i = 0; i < n; i++) begin
      r.value   = pick_value(flavor);
      r.is_last = (i + 1 == n);
      req_queue = {req_queue, r};
    end
  endtask

  // driver
  always @(posedge clk_i) begin
    logic took;
    logic rest;
    logic calm;
    took = start && !busy;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (took) begin
        absorb_element(req);
        void'(req_queue.pop_front());
        n_sent++;
      end
      if (!(start && !took)) begin
        calm = (n_sent >= 140 && n_sent < 240);
        rest = (n_sent == hold_at && sorted_expect.size() != 0) ||
               (!calm && $urandom_range(0, 99) < 23);
        if (req_queue.size() != 0 && !rest) begin
          start <= 1'b1;
          req   <= req_queue[0];
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    out_res_t exp_res;
    if (rst_ni && res_valid_o) begin
      if (sorted_expect.size() == 0) begin
        $error("unexpected result: sorted_value=%0d", res_o.sorted_value);
        n_errors++;
      end else begin
        exp_res = sorted_expect.pop_front();
        if (res_o.sorted_value !== exp_res.sorted_value) begin
          $error("sorted_value: expected %0d, got %0d",
                 exp_res.sorted_value, res_o.sorted_value);
          n_errors++;
        end
        if (res_o.end_of_set !== exp_res.end_of_set) begin
          $error("end_of_set: expected %0b, got %0b", exp_res.end_of_set, res_o.end_of_set);
          n_errors++;
        end
        if (res_o.overflowed !== exp_res.overflowed) begin
          $error("overflowed: expected %0b, got %0b", exp_res.overflowed, res_o.overflowed);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("shell_sort_halving_gaps_tb: FAIL");
      $finish;
    end
  end

  initial begin
    in_req_t     r;
    int unsigned n;
    int unsigned pct;
    elem_cnt = 0;
    dropped  = 1'b0;
    n_sent   = 0;
    n_errors = 0;
    cycles   = 0;

    // single-element set
    r.value = ValMin; r.is_last = 1'b1; req_queue = {req_queue, r};
    // extremes and sign boundary
    r.is_last = 1'b0;
    r.value = ValMax; req_queue = {req_queue, r};
    r.value = ValMin; req_queue = {req_queue, r};
    r.value = 32'sd0; req_queue = {req_queue, r};
    r.value = -32'sd1; req_queue = {req_queue, r};
    r.value = 32'sd1; r.is_last = 1'b1; req_queue = {req_queue, r};
    // full store with duplicates, last element dropped
    for (int unsigned i = 0; i < MaxElements; i++) begin
      r.is_last = 1'b0;
      case (i % 4)
        0: r.value = ValMax;
        1: r.value = 32'sd7;
        2: r.value = ValMin;
        default: r.value = $signed(32'(MaxElements - i)) - 32'sd8;
      endcase
      req_queue = {req_queue, r};
    end
    r.value = 32'sd3; r.is_last = 1'b1; req_queue = {req_queue, r};
    hold_at = req_queue.size();

    n = 0;
    while (n < RandItems) begin
      pct = $urandom_range(0, 99);
      if (pct < 10) begin
        queue_set($urandom_range(MaxElements + 1, MaxElements + 4), $urandom_range(0, 3));
        n += MaxElements;
      end else begin
        if (pct < 20) queue_set(1, $urandom_range(0, 3));
        else queue_set($urandom_range(2, MaxElements), $urandom_range(0, 3));
        n = req_queue.size() - hold_at;
      end
      if (req_queue.size() - hold_at > n) n = req_queue.size() - hold_at;
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i); while (req_queue.size() != 0 || sorted_expect.size() != 0);
    repeat (TailCycles) @(posedge clk_i);

    if (n_errors == 0 && sorted_expect.size() == 0) begin
      $display("shell_sort_halving_gaps_tb: PASS");
    end else begin
      $display("shell_sort_halving_gaps_tb: FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/ssh_pkg.sv
rtl/ssh_cell.sv
rtl/ssh_ctrl.sv
rtl/shell_sort_halving_gaps.sv
rtl/ssh_checker.sv
verif/shell_sort_halving_gaps_tb.sv
